### rtl/assert_macros.svh
// Assertion macros for the RTL; tw_back includes them.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked property, skipped while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

### rtl/tw_pkg.sv
`default_nettype none

package tw_pkg;

  // field widths fixed by the interface
  localparam int DELAY_W  = 16;
  localparam int HANDLE_W = 32;

  // request codes
  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_EXPIRE  = 2'd1;
  localparam logic [1:0] REQ_ADVANCE = 2'd2;
  localparam logic [1:0] REQ_RSVD    = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_ADDED    = 3'd0;
  localparam logic [2:0] STAT_EXPIRED  = 3'd1;
  localparam logic [2:0] STAT_EMPTY    = 3'd2;
  localparam logic [2:0] STAT_ADVANCED = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;

  // depth of the command and result queues
  localparam int Q_DEPTH = 4;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [1:0]          req_type;
    logic [HANDLE_W-1:0] handle;
    logic [DELAY_W-1:0]  delay;
  } in_word_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [HANDLE_W-1:0] out_handle;
    logic                last;
  } out_word_t;

  // classified command: offset is delay mod slot count
  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] handle;
    logic [DELAY_W-1:0]  offset;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/tw_fifo.sv
`default_nettype none

module tw_fifo #(
  parameter int W     = 1,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [W-1:0]               wr_data,
  output logic                       full,
  input  logic                       rd_en,
  output logic [W-1:0]               rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= CNT_W'(count + 1'b1);
        2'b01:   count <= CNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### rtl/tw_front.sv
`default_nettype none

module tw_front #(
  parameter int WHEEL_SLOTS = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  tw_pkg::in_word_t item,
  input  logic             push,
  input  logic             hold,
  output logic             full,
  output tw_pkg::cmd_t     cmd,
  output logic             cmd_push,
  input  logic             cmd_full
);

  import tw_pkg::*;

  // delay mod slots via reciprocal: exact for every 16-bit delay
  localparam int SLOT_W = $clog2(WHEEL_SLOTS);
  localparam int SHIFT  = DELAY_W + SLOT_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS);
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = DELAY_W + RECIP_W;

  logic                en;
  logic                take;
  logic [PROD_W-1:0]   prod;

  logic                s1_v;
  logic [1:0]          s1_kind;
  logic [HANDLE_W-1:0] s1_handle;
  logic [DELAY_W-1:0]  s1_delay;
  logic [DELAY_W-1:0]  s1_quot;

  logic                s2_v;
  logic [1:0]          s2_kind;
  logic [HANDLE_W-1:0] s2_handle;
  logic [DELAY_W-1:0]  s2_offset;

  // pipeline moves unless the last stage is stuck on a full queue
  assign en   = !(s2_v && cmd_full);
  assign take = push && en && !hold;
  assign full = !en || hold;
  assign prod = PROD_W'(item.delay) * PROD_W'(RECIP);

  // stage valids; unused request code is dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (en) begin
      s1_v <= take && (item.req_type != REQ_RSVD);
      s2_v <= s1_v;
    end
  end

  // quotient estimate, then remainder
  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind   <= item.req_type;
      s1_handle <= item.handle;
      s1_delay  <= item.delay;
      s1_quot   <= DELAY_W'(prod >> SHIFT);
      s2_kind   <= s1_kind;
      s2_handle <= s1_handle;
      s2_offset <= s1_delay - DELAY_W'(s1_quot * DELAY_W'(WHEEL_SLOTS));
    end
  end

  assign cmd      = '{kind: s2_kind, handle: s2_handle, offset: s2_offset};
  assign cmd_push = s2_v && !cmd_full;

endmodule

`default_nettype wire

### rtl/tw_back.sv
`default_nettype none
`include "assert_macros.svh"

module tw_back #(
  parameter int WHEEL_SLOTS = 512,
  parameter int BUCKET_CAP  = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tw_pkg::cmd_t               cmd,
  input  logic                       cmd_empty,
  output logic                       cmd_pop,
  input  logic [tw_pkg::Q_CNT_W-1:0] res_count,
  output tw_pkg::out_word_t          res,
  output logic                       res_push,
  output logic                       clearing
);

  import tw_pkg::*;

  localparam int SW     = $clog2(WHEEL_SLOTS);
  localparam int IW     = (BUCKET_CAP > 1) ? $clog2(BUCKET_CAP) : 1;
  localparam int CW     = $clog2(BUCKET_CAP + 1);
  localparam int HW     = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int BDEPTH = WHEEL_SLOTS << IW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_EXP_CNT,
    S_EXP_RUN
  } state_t;

  state_t         state;
  logic [SW-1:0]  cur;
  logic [SW-1:0]  clr_idx;
  logic [SW-1:0]  slot_sel;
  logic [HW-1:0]  hnd;
  logic [CW-1:0]  exp_n;
  logic [CW-1:0]  exp_i;
  logic           rd_pend;
  logic           rd_last;

  // slot counts and bucket entries
  logic [CW-1:0]  cnt_mem [WHEEL_SLOTS];
  logic [CW-1:0]  cnt_q;
  logic           cnt_re;
  logic [SW-1:0]  cnt_raddr;
  logic           cnt_we;
  logic [SW-1:0]  cnt_waddr;
  logic [CW-1:0]  cnt_wdata;

  logic [HW-1:0]    bkt_mem [BDEPTH];
  logic [HW-1:0]    bkt_q;
  logic             bkt_re;
  logic [SW+IW-1:0] bkt_raddr;
  logic             bkt_we;
  logic [SW+IW-1:0] bkt_waddr;

  logic           take;
  logic           is_add;
  logic           is_exp;
  logic           is_adv;
  logic           room;
  logic           add_ok;
  logic           issue;
  logic           fin;
  logic [CW-1:0]  exp_i_inc;
  logic [SW:0]    add_sum;
  logic [SW-1:0]  add_slot;
  logic [SW-1:0]  cur_inc;

  // decode and handshake toward both queues
  assign is_add    = (cmd.kind == REQ_ADD);
  assign is_exp    = (cmd.kind == REQ_EXPIRE);
  assign is_adv    = (cmd.kind == REQ_ADVANCE);
  assign room      = (Q_CNT_W'(res_count + Q_CNT_W'(rd_pend)) < Q_CNT_W'(Q_DEPTH));
  assign take      = (state == S_IDLE) && !cmd_empty && !rd_pend &&
                     (res_count < Q_CNT_W'(Q_DEPTH));
  assign cmd_pop   = take;
  assign add_ok    = (state == S_ADD) && (cnt_q < CW'(BUCKET_CAP));
  assign issue     = (state == S_EXP_RUN) && room;
  assign exp_i_inc = CW'(exp_i + 1'b1);
  assign fin       = (exp_i_inc == exp_n);
  assign clearing  = (state == S_CLEAR);

  // target slot of an add, wrapping
  assign add_sum  = {1'b0, cur} + {1'b0, cmd.offset[SW-1:0]};
  assign add_slot = (add_sum >= (SW+1)'(WHEEL_SLOTS)) ?
                    SW'(add_sum - (SW+1)'(WHEEL_SLOTS)) : SW'(add_sum);
  assign cur_inc  = (cur == SW'(WHEEL_SLOTS - 1)) ? '0 : SW'(cur + 1'b1);

  // count memory port control
  assign cnt_re    = take;
  assign cnt_raddr = is_add ? add_slot : cur;
  assign cnt_we    = (state == S_CLEAR) || (take && is_adv) || add_ok;
  assign cnt_wdata = add_ok ? CW'(cnt_q + 1'b1) : '0;
  always_comb begin
    case (state)
      S_CLEAR: cnt_waddr = clr_idx;
      S_ADD:   cnt_waddr = slot_sel;
      default: cnt_waddr = cur;
    endcase
  end

  // bucket memory port control
  assign bkt_we    = add_ok;
  assign bkt_waddr = {slot_sel, cnt_q[IW-1:0]};
  assign bkt_re    = issue;
  assign bkt_raddr = {cur, exp_i[IW-1:0]};

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_q <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= hnd;
    end
    if (bkt_re) begin
      bkt_q <= bkt_mem[bkt_raddr];
    end
  end

  // result word; the sources never coincide
  always_comb begin
    res_push = 1'b0;
    res      = '0;
    if (take && is_adv) begin
      res_push = 1'b1;
      res      = '{status: STAT_ADVANCED, out_handle: '0, last: 1'b1};
    end else if (state == S_ADD) begin
      res_push = 1'b1;
      res      = '{status: (add_ok ? STAT_ADDED : STAT_FULL), out_handle: '0, last: 1'b1};
    end else if ((state == S_EXP_CNT) && (cnt_q == '0)) begin
      res_push = 1'b1;
      res      = '{status: STAT_EMPTY, out_handle: '0, last: 1'b1};
    end else if (rd_pend) begin
      res_push = 1'b1;
      res      = '{status: STAT_EXPIRED, out_handle: HANDLE_W'(bkt_q), last: rd_last};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      cur     <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= issue;
      rd_last <= fin;
      case (state)
        S_CLEAR: begin
          clr_idx <= SW'(clr_idx + 1'b1);
          if (clr_idx == SW'(WHEEL_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            if (is_add) begin
              slot_sel <= add_slot;
              hnd      <= cmd.handle[HW-1:0];
              state    <= S_ADD;
            end else if (is_exp) begin
              state <= S_EXP_CNT;
            end else if (is_adv) begin
              cur <= cur_inc;
            end
          end
        end
        S_ADD: begin
          state <= S_IDLE;
        end
        S_EXP_CNT: begin
          exp_n <= cnt_q;
          exp_i <= '0;
          state <= (cnt_q == '0) ? S_IDLE : S_EXP_RUN;
        end
        S_EXP_RUN: begin
          if (issue) begin
            exp_i <= exp_i_inc;
            if (fin) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `ASSERT_CLK(a_res_room, clk, rst, res_push |-> (res_count < Q_CNT_W'(Q_DEPTH)), "result queue overrun")
  `ASSERT_NEVER(a_pend_take, clk, rst, rd_pend && cmd_pop, "command taken during bucket read")
  `ASSERT_CLK(a_exp_end, clk, rst, (issue && fin) |=> (state == S_IDLE) && rd_pend, "expire stream did not close")
  `ASSERT_CLK(a_exp_idx, clk, rst, (state == S_EXP_RUN) |-> (exp_i < exp_n), "expire index past count")
  `ASSERT_CLK(a_cur_hold, clk, rst, !(cmd_pop && is_adv) |=> $stable(cur), "slot moved without advance")

endmodule

`default_nettype wire

### rtl/timing_wheel_expiry.sv
`default_nettype none
// Channel  Direction  Handshake                   Word
// item     in         push & !full                req_type, handle, delay
// result   out        pop & !empty                status, out_handle, last
//
// Front: a delay-mod-slots pipeline (stages s1, s2) into a 4-word command queue.
// Back: add reads the slot count, then writes bucket and count in S_ADD; advance
// zeroes the current slot count; expire reads the count memory, then does one
// registered bucket-memory read per handle, and the last word lands before the
// next command; an empty expire answers from the count alone. Reset: synchronous;
// then a clearing pass zeroes every slot count in turn, with full held high.
// Stalls: results wait in a 4-word queue; the back pauses when it is full, and
// full rises on the input once the command queue backs up.

module timing_wheel_expiry #(
  parameter int WHEEL_SLOTS = 512,
  parameter int BUCKET_CAP  = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  tw_pkg::in_word_t  item,
  input  logic              push,
  output logic              full,
  output tw_pkg::out_word_t result,
  output logic              empty,
  input  logic              pop
);

  import tw_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(out_word_t);

  cmd_t               cmd_in;
  logic               cmd_push;
  logic               cmd_full;
  logic [CMD_W-1:0]   cmd_bits;
  logic               cmd_empty;
  logic               cmd_pop;
  logic               clearing;

  out_word_t          res_in;
  logic               res_push;
  logic [Q_CNT_W-1:0] res_count;
  logic [RES_W-1:0]   res_bits;

  // front: accept and classify
  tw_front #(
    .WHEEL_SLOTS(WHEEL_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .push     (push),
    .hold     (clearing),
    .full     (full),
    .cmd      (cmd_in),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full)
  );

  // command queue between front and back
  tw_fifo #(
    .W     (CMD_W),
    .DEPTH (Q_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_bits),
    .empty   (cmd_empty),
    .count   ()
  );

  // back: wheel state and memories
  tw_back #(
    .WHEEL_SLOTS (WHEEL_SLOTS),
    .BUCKET_CAP  (BUCKET_CAP),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_t'(cmd_bits)),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res       (res_in),
    .res_push  (res_push),
    .clearing  (clearing)
  );

  // result queue toward the consumer
  tw_fifo #(
    .W     (RES_W),
    .DEPTH (Q_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (),
    .rd_en   (pop),
    .rd_data (res_bits),
    .empty   (empty),
    .count   (res_count)
  );

  assign result = out_word_t'(res_bits);

endmodule

`default_nettype wire

### tb/sv/tw_expiry_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the timing wheel, predicts every result word and
// compares each popped word against the oldest prediction.
module tw_expiry_checker #(
  parameter int WHEEL_SLOTS = 512,
  parameter int BUCKET_CAP  = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  tw_pkg::in_word_t  item,
  input  logic              push,
  input  logic              full,
  input  tw_pkg::out_word_t result,
  input  logic              empty,
  input  logic              pop,
  output int                errors,
  output int                pending
);

  import tw_pkg::*;

  localparam logic [HANDLE_W-1:0] HANDLE_MASK =
    (HANDLE_BITS >= HANDLE_W) ? '1 : HANDLE_W'((64'd1 << HANDLE_BITS) - 64'd1);

  // shadow of the wheel
  int unsigned         cur_slot;
  int unsigned         fill_cnt [WHEEL_SLOTS];
  logic [HANDLE_W-1:0] bucket_mem [WHEEL_SLOTS * BUCKET_CAP];

  // result words still owed by the block, oldest first
  out_word_t           owed_q [$];
  int                  err_cnt = 0;

  // append one owed word behind the older ones
  function automatic void owe_word(input out_word_t w);
    owed_q = {owed_q, w};
  endfunction

  // apply one accepted request to the shadow wheel and queue what it owes
  task automatic file_request(input in_word_t w);
    int unsigned slot;
    int unsigned n;
    out_word_t   r;
    r = '0;
    r.last = 1'b1;
    case (w.req_type)
      REQ_ADD: begin
        slot = (cur_slot + int'(w.delay) % WHEEL_SLOTS) % WHEEL_SLOTS;
        n = fill_cnt[slot];
        if (n >= BUCKET_CAP) begin
          r.status = STAT_FULL;
        end else begin
          bucket_mem[slot * BUCKET_CAP + n] = w.handle & HANDLE_MASK;
          fill_cnt[slot] = n + 1;
          r.status = STAT_ADDED;
        end
        owe_word(r);
      end
      REQ_EXPIRE: begin
        n = fill_cnt[cur_slot];
        if (n > BUCKET_CAP) n = BUCKET_CAP;
        if (n == 0) begin
          r.status = STAT_EMPTY;
          owe_word(r);
        end else begin
          // slot is streamed in filing order and left as it is
          for (int unsigned i = 0; i < n; i++) begin
            r.status = STAT_EXPIRED;
            r.out_handle = bucket_mem[cur_slot * BUCKET_CAP + i];
            r.last = (i + 1 == n);
            owe_word(r);
          end
        end
      end
      REQ_ADVANCE: begin
        fill_cnt[cur_slot] = 0;
        cur_slot = (cur_slot + 1) % WHEEL_SLOTS;
        r.status = STAT_ADVANCED;
        owe_word(r);
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      cur_slot = 0;
      foreach (fill_cnt[i]) fill_cnt[i] = 0;
      owed_q.delete();
    end else begin
      // compare a popped word with the oldest owed one
      if (pop && !empty) begin
        if (owed_q.size() == 0) begin
          $error("result word with nothing owed: status %0d handle %h last %0d",
                 result.status, result.out_handle, result.last);
          err_cnt++;
        end else begin
          want = owed_q.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            err_cnt++;
          end
          if (result.out_handle !== want.out_handle) begin
            $error("out_handle: expected %h, got %h", want.out_handle, result.out_handle);
            err_cnt++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, result.last);
            err_cnt++;
          end
        end
      end
      if (push && !full) file_request(item);
    end
    pending <= owed_q.size();
    errors  <= err_cnt;
  end

endmodule

### tb/sv/tb_timing_wheel_expiry.sv
`timescale 1ns / 100ps

module tb_timing_wheel_expiry;
  import tw_pkg::*;

  localparam int WHEEL_SLOTS  = 512;
  localparam int BUCKET_CAP   = 32;
  localparam int HANDLE_BITS  = 32;
  localparam int RAND_ITEMS   = 245;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 60000;

  logic      clk  = 1'b0;
  logic      rst  = 1'b1;
  in_word_t  item = '0;
  logic      push = 1'b0;
  logic      pop  = 1'b0;
  logic      full;
  logic      empty;
  out_word_t result;
  int        errors;
  int        pending;

  bit        sender_calm = 1'b0;
  int        cycles = 0;

  always #10 clk = ~clk;

  timing_wheel_expiry #(
    .WHEEL_SLOTS(WHEEL_SLOTS),
    .BUCKET_CAP (BUCKET_CAP),
    .HANDLE_BITS(HANDLE_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .push  (push),
    .full  (full),
    .result(result),
    .empty (empty),
    .pop   (pop)
  );

  tw_expiry_checker #(
    .WHEEL_SLOTS(WHEEL_SLOTS),
    .BUCKET_CAP (BUCKET_CAP),
    .HANDLE_BITS(HANDLE_BITS)
  ) checker_i (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .push   (push),
    .full   (full),
    .result (result),
    .empty  (empty),
    .pop    (pop),
    .errors (errors),
    .pending(pending)
  );

  // offer one request word, with random idle cycles ahead of it unless calm
  task automatic send_req(input logic [1:0] kind, input logic [HANDLE_W-1:0] hnd,
                          input logic [DELAY_W-1:0] dly);
    while (!sender_calm && $urandom_range(0, 99) < 25) begin
      push <= 1'b0;
      @(posedge clk);
    end
    item.req_type <= kind;
    item.handle   <= hnd;
    item.delay    <= dly;
    push          <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_timing_wheel_expiry: errors");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off, then a calm stretch
  initial begin : drain_side
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) taken++;
      if (!held && taken >= 20) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= (taken >= 150 && taken < 300) || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  initial begin : feed_side
    int unsigned sent;
    int unsigned ofs;
    int unsigned n;
    int unsigned pick;
    bit          first_fill;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, delay wrap, repeated expire, empty slot, unused code
    send_req(REQ_ADD, '0, '0);
    send_req(REQ_ADD, '1, '1);
    send_req(REQ_ADD, 32'hA5A5_5A5A, DELAY_W'(WHEEL_SLOTS));
    send_req(REQ_ADD, $urandom, 16'd1);
    send_req(REQ_EXPIRE, '0, '0);
    send_req(REQ_EXPIRE, '1, '1);
    send_req(REQ_RSVD, $urandom, 16'($urandom));
    send_req(REQ_ADVANCE, '0, '0);
    send_req(REQ_EXPIRE, $urandom, 16'($urandom));
    send_req(REQ_ADVANCE, '1, '1);
    send_req(REQ_EXPIRE, '0, '0);
    send_req(REQ_ADD, $urandom, DELAY_W'(WHEEL_SLOTS - 2));
    send_req(REQ_ADD, $urandom, 16'h8001);
    send_req(REQ_ADVANCE, $urandom, 16'($urandom));
    send_req(REQ_EXPIRE, '0, '0);
    send_req(REQ_RSVD, '1, '1);
    send_req(REQ_ADVANCE, '0, '0);
    send_req(REQ_ADVANCE, '0, '0);
    send_req(REQ_EXPIRE, '0, '0);

    // random: bucket fill bursts mixed with short random runs
    sent = 0;
    first_fill = 1'b1;
    while (sent < RAND_ITEMS) begin
      sender_calm = (sent >= 100 && sent < 160);
      if (first_fill || $urandom_range(0, 4) == 0) begin
        // fill one bucket (the first time past its capacity), walk to it, stream it out
        ofs = $urandom_range(0, 3);
        n = first_fill ? BUCKET_CAP + 3 : $urandom_range(BUCKET_CAP - 4, BUCKET_CAP + 4);
        first_fill = 1'b0;
        repeat (n)
          send_req(REQ_ADD, $urandom,
                   DELAY_W'(ofs + WHEEL_SLOTS * $urandom_range(0, (65535 - 3) / WHEEL_SLOTS)));
        repeat (ofs) send_req(REQ_ADVANCE, $urandom, 16'($urandom));
        send_req(REQ_EXPIRE, $urandom, 16'($urandom));
        sent += n + ofs + 1;
      end else begin
        repeat ($urandom_range(4, 10)) begin
          pick = $urandom_range(0, 99);
          if (pick < 50) begin
            send_req(REQ_ADD, $urandom,
                     (pick < 40) ? 16'($urandom_range(0, 7)) : 16'($urandom));
            sent++;
          end else if (pick < 75) begin
            send_req(REQ_EXPIRE, $urandom, 16'($urandom));
            sent++;
          end else if (pick < 95) begin
            send_req(REQ_ADVANCE, $urandom, 16'($urandom));
            sent++;
          end else begin
            send_req(REQ_RSVD, $urandom, 16'($urandom));
          end
        end
      end
    end
    sender_calm = 1'b0;
    push <= 1'b0;

    // wait for every owed word, then let the pipeline settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_timing_wheel_expiry: clean");
    end else begin
      $display("tb_timing_wheel_expiry: errors");
    end
    $finish;
  end

endmodule

### timing_wheel_expiry.f
+incdir+rtl
rtl/tw_pkg.sv
rtl/tw_fifo.sv
rtl/tw_front.sv
rtl/tw_back.sv
rtl/timing_wheel_expiry.sv
tb/sv/tw_expiry_checker.sv
tb/sv/tb_timing_wheel_expiry.sv
